[rtl/core/bted_pkg.sv]
// ----------------------------------------------------------------------------
// bted_pkg
// Types and constants shared by the trigger edge detector.
// ----------------------------------------------------------------------------
package bted_pkg;

  localparam int MAX_BLOCK = 65536;
  localparam int POS_W     = $clog2(MAX_BLOCK);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BLOCK - 1);

  localparam int SAMPLE_W  = 32;
  localparam int INDEX_W   = 32;
  localparam int CHANNEL_W = 10;
  localparam int SCORE_W   = SAMPLE_W + 2;
  localparam int LEVEL_W   = SAMPLE_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DETECT_MODE   = 2'd0,
    REG_EDGE_FALLING  = 2'd1,
    REG_REMOVE_OFFSET = 2'd2,
    REG_THRESHOLD     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_MAX      = 1'b0,
    MODE_GRADIENT = 1'b1
  } detect_mode_t;

  typedef struct packed {
    detect_mode_t                detect_mode;
    logic                        edge_falling;
    logic                        remove_offset;
    logic signed [SAMPLE_W-1:0]  threshold;
  } cfg_t;

  // end-of-block candidate handed to the threshold test
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  value_at_best;
    logic signed [SAMPLE_W-1:0]  first_value;
    logic [INDEX_W-1:0]          block_start;
    logic [POS_W-1:0]            best_offset;
    logic [CHANNEL_W-1:0]        channel;
  } cand_t;

endpackage

[rtl/core/bted_in_if.sv]
// ----------------------------------------------------------------------------
// bted_in_if
// Sample item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bted_in_if
  import bted_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [INDEX_W-1:0]          block_start;
  logic [CHANNEL_W-1:0]        channel;
  logic                        block_last;

  modport source (output valid, sample, block_start, channel, block_last, input ready);
  modport sink   (input valid, sample, block_start, channel, block_last, output ready);
endinterface

[rtl/core/bted_out_if.sv]
// ----------------------------------------------------------------------------
// bted_out_if
// Trigger result item channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bted_out_if
  import bted_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CHANNEL_W-1:0]  trigger_channel;
  logic [INDEX_W-1:0]    trigger_position;

  modport source (output valid, trigger_channel, trigger_position, input ready);
  modport sink   (input valid, trigger_channel, trigger_position, output ready);
endinterface

[rtl/core/bted_tracker.sv]
// ----------------------------------------------------------------------------
// bted_tracker
// Running per-block search for the largest sample or sample difference.
// ----------------------------------------------------------------------------
module bted_tracker
  import bted_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  input  logic                        item_fire,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic [INDEX_W-1:0]          block_start,
  input  logic [CHANNEL_W-1:0]        channel,
  input  logic                        block_last,
  input  logic                        cand_ready,
  output logic                        cand_valid,
  output cand_t                       cand
);

  logic                        in_block_r, in_block_nxt;
  logic signed [SAMPLE_W-1:0]  first_value_r, first_value_nxt;
  logic signed [SAMPLE_W-1:0]  prev_value_r;
  logic signed [SCORE_W-1:0]   best_score_r, best_score_nxt;
  logic [POS_W-1:0]            best_offset_r, best_offset_nxt;
  logic signed [SAMPLE_W-1:0]  value_at_best_r, value_at_best_nxt;
  logic [POS_W-1:0]            position_r, position_nxt;
  logic [INDEX_W-1:0]          start_r, start_nxt;
  logic [CHANNEL_W-1:0]        channel_r, channel_nxt;
  logic signed [SCORE_W-1:0]   score;
  logic signed [SCORE_W-1:0]   diff;
  logic                        cand_valid_r;
  cand_t                       cand_r;

  always_comb begin
    diff = SCORE_W'(sample) - SCORE_W'(prev_value_r);
    if (cfg.detect_mode == MODE_GRADIENT) begin
      score = cfg.edge_falling ? -diff : diff;
    end else begin
      score = SCORE_W'(sample);
    end
  end

  always_comb begin
    in_block_nxt      = 1'b1;
    first_value_nxt   = first_value_r;
    best_score_nxt    = best_score_r;
    best_offset_nxt   = best_offset_r;
    value_at_best_nxt = value_at_best_r;
    position_nxt      = position_r;
    start_nxt         = start_r;
    channel_nxt       = channel_r;
    if (!in_block_r) begin
      first_value_nxt   = sample;
      start_nxt         = block_start;
      channel_nxt       = channel;
      position_nxt      = '0;
      best_offset_nxt   = '0;
      value_at_best_nxt = sample;
      best_score_nxt    = (cfg.detect_mode == MODE_GRADIENT) ? '0 : SCORE_W'(sample);
    end else begin
      if (position_r != POS_LAST) begin
        position_nxt = position_r + POS_W'(1);
      end
      if (score > best_score_r) begin
        best_score_nxt    = score;
        best_offset_nxt   = position_nxt;
        value_at_best_nxt = sample;
      end
    end
    if (block_last) begin
      in_block_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r      <= 1'b0;
      first_value_r   <= '0;
      prev_value_r    <= '0;
      best_score_r    <= '0;
      best_offset_r   <= '0;
      value_at_best_r <= '0;
      position_r      <= '0;
      start_r         <= '0;
      channel_r       <= '0;
    end else if (item_fire) begin
      in_block_r      <= in_block_nxt;
      first_value_r   <= first_value_nxt;
      prev_value_r    <= sample;
      best_score_r    <= best_score_nxt;
      best_offset_r   <= best_offset_nxt;
      value_at_best_r <= value_at_best_nxt;
      position_r      <= position_nxt;
      start_r         <= start_nxt;
      channel_r       <= channel_nxt;
    end
  end

  // candidate register, loaded on the last item of a block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_valid_r <= 1'b0;
    end else if (item_fire && block_last) begin
      cand_valid_r <= 1'b1;
    end else if (cand_ready) begin
      cand_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire && block_last) begin
      cand_r.value_at_best <= value_at_best_nxt;
      cand_r.first_value   <= first_value_nxt;
      cand_r.block_start   <= start_nxt;
      cand_r.best_offset   <= best_offset_nxt;
      cand_r.channel       <= channel_nxt;
    end
  end

  assign cand_valid = cand_valid_r;
  assign cand       = cand_r;

endmodule

[rtl/core/bted_test.sv]
// ----------------------------------------------------------------------------
// bted_test
// Threshold test of the block candidate and the result register.
// ----------------------------------------------------------------------------
module bted_test
  import bted_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          cand_valid,
  input  cand_t         cand,
  output logic          cand_ready,
  bted_out_if.source    out_ch
);

  logic signed [LEVEL_W-1:0]  level;
  logic                       pass;
  logic                       out_free;
  logic                       out_valid_r;
  logic [CHANNEL_W-1:0]       trig_channel_r;
  logic [INDEX_W-1:0]         trig_position_r;

  always_comb begin
    level = LEVEL_W'(cand.value_at_best);
    if (cfg.remove_offset) begin
      level = LEVEL_W'(cand.value_at_best) - LEVEL_W'(cand.first_value);
    end
    pass = level > LEVEL_W'(cfg.threshold);
  end

  assign out_free   = !out_valid_r || out_ch.ready;
  // a failing candidate is dropped without waiting for the output
  assign cand_ready = !pass || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= cand_valid && pass;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && cand_valid && pass) begin
      trig_channel_r  <= cand.channel;
      trig_position_r <= cand.block_start + INDEX_W'(cand.best_offset);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.trigger_channel  = trig_channel_r;
  assign out_ch.trigger_position = trig_position_r;

endmodule

[rtl/core/block_trigger_edge_detector.sv]
// An accepted last item's result passes the candidate register, then the result register.
// Throughput: one item per cycle when no last item is stalled; the per-item compare and update
// of the running best sits in a single stage between the input register and the block state.
// A block's end adds no gap; a result waiting at the output stalls only a further last item.
// Reset (rst_n low, synchronous) empties all stages, ends any open block and restores registers.
// ----------------------------------------------------------------------------
// block_trigger_edge_detector
// Per-block trigger edge search with threshold test, max or gradient mode.
// ----------------------------------------------------------------------------
module block_trigger_edge_detector
  import bted_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  bted_in_if.sink                in_ch,
  bted_out_if.source             out_ch
);

  cfg_t                        cfg_r;
  logic                        in_valid_r;
  logic signed [SAMPLE_W-1:0]  in_sample_r;
  logic [INDEX_W-1:0]          in_start_r;
  logic [CHANNEL_W-1:0]        in_channel_r;
  logic                        in_last_r;
  logic                        item_fire;
  logic                        cand_valid;
  logic                        cand_ready;
  logic                        cand_free;
  cand_t                       cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_mode   <= MODE_MAX;
      cfg_r.edge_falling  <= 1'b0;
      cfg_r.remove_offset <= 1'b1;
      cfg_r.threshold     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_DETECT_MODE:   cfg_r.detect_mode   <= detect_mode_t'(cfg_wdata[0]);
        REG_EDGE_FALLING:  cfg_r.edge_falling  <= cfg_wdata[0];
        REG_REMOVE_OFFSET: cfg_r.remove_offset <= cfg_wdata[0];
        REG_THRESHOLD:     cfg_r.threshold     <= SAMPLE_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // only a last item needs room in the candidate register
  assign cand_free = !cand_valid || cand_ready;
  assign item_fire = in_valid_r && (!in_last_r || cand_free);
  assign in_ch.ready = !in_valid_r || item_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_sample_r  <= in_ch.sample;
      in_start_r   <= in_ch.block_start;
      in_channel_r <= in_ch.channel;
      in_last_r    <= in_ch.block_last;
    end
  end

  bted_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_fire   (item_fire),
    .sample      (in_sample_r),
    .block_start (in_start_r),
    .channel     (in_channel_r),
    .block_last  (in_last_r),
    .cand_ready  (cand_ready),
    .cand_valid  (cand_valid),
    .cand        (cand)
  );

  bted_test u_test (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cand_valid (cand_valid),
    .cand       (cand),
    .cand_ready (cand_ready),
    .out_ch     (out_ch)
  );

endmodule
